// ===== sv/dotq_pkg.sv =====
// ----------------------------------------------------------------------------
// dotq_pkg
// Types and constants of the deadline-ordered task queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  localparam logic [31:0] DEFAULT_DEADLINE_RESET = 32'd10000;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] task_id;
    logic [31:0] deadline;
    logic [7:0]  type_code;
  } dotq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_id;
    logic [31:0] removed_deadline;
    logic [7:0]  removed_type;
    logic        head_valid;
    logic [31:0] head_id;
    logic [31:0] head_deadline;
    logic [4:0]  entry_count;
  } dotq_out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [7:0]  type_code;
  } dotq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_POP_RD,
    ST_POP_LD,
    ST_DONE
  } dotq_state_t;

endpackage

// ===== sv/dotq_mem.sv =====
// ----------------------------------------------------------------------------
// dotq_mem
// Single-port entry memory with registered read data.
// ----------------------------------------------------------------------------
module dotq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  dotq_pkg::dotq_entry_t wdata,
  output dotq_pkg::dotq_entry_t rdata
);
  import dotq_pkg::*;

  dotq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/deadline_ordered_task_queue_top.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue_top
// Earliest-deadline-first task queue kept sorted in a ring memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    dotq_in_t  (insert or pop request)
// out_      output     out_valid / out_ready  dotq_out_t (status, removed, head)
// cfg_      input      cfg_we                 32-bit default deadline
//
// An insert walks from the tail toward the head: one read, then one compare
// and shift write per entry moved; an insert that becomes the head ends with
// a write of the head slot. A pop reads and loads the new head; a pop that
// empties the queue and a dropped request go straight to done.
// Reset empties the queue at once; no clearing pass.
// in_ready is high only in idle; a stalled result holds the sequencer in done.
// ----------------------------------------------------------------------------
module deadline_ordered_task_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dotq_pkg::dotq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dotq_pkg::dotq_out_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import dotq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dotq_state_t state_r, state_nxt;

  logic [31:0]   default_deadline_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] head_ptr_r;
  logic [PW-1:0] k_r;
  dotq_entry_t   req_r;
  dotq_entry_t   head_r;
  dotq_entry_t   removed_r;
  logic [1:0]    status_r;
  logic          out_valid_r;
  dotq_out_t     out_data_r;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          shift;
  logic          mem_we;
  logic [PW-1:0] mem_off;
  logic [PW-1:0] mem_addr;
  dotq_entry_t   mem_wdata;
  dotq_entry_t   mem_rdata;
  logic [PW:0]   ring_sum;

  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign shift    = (mem_rdata.deadline >= req_r.deadline);

  assign ring_sum = {1'b0, head_ptr_r} + {1'b0, mem_off};
  assign mem_addr = (ring_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(ring_sum - (PW+1)'(QUEUE_DEPTH)) : ring_sum[PW-1:0];

  dotq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_INSERT) begin
            if (is_full) state_nxt = ST_DONE;
            else if (is_empty) state_nxt = ST_INS_WR;
            else state_nxt = ST_INS_RD;
          end else begin
            if (is_empty || count_r == CW'(1)) state_nxt = ST_DONE;
            else state_nxt = ST_POP_RD;
          end
        end
      end
      ST_INS_RD:  state_nxt = ST_INS_CMP;
      ST_INS_CMP: begin
        if (!shift) state_nxt = ST_DONE;
        else if (k_r == PW'(1)) state_nxt = ST_INS_WR;
        else state_nxt = ST_INS_RD;
      end
      ST_INS_WR:  state_nxt = ST_DONE;
      ST_POP_RD:  state_nxt = ST_POP_LD;
      ST_POP_LD:  state_nxt = ST_DONE;
      ST_DONE:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_off   = '0;
    mem_wdata = req_r;
    unique case (state_r)
      ST_IDLE:    begin
        in_ready = 1'b1;
        mem_off  = PW'(1);
      end
      ST_INS_RD:  mem_off = k_r - PW'(1);
      ST_INS_CMP: begin
        mem_we  = 1'b1;
        mem_off = k_r;
        if (shift) mem_wdata = mem_rdata;
      end
      ST_INS_WR:  mem_we = 1'b1;
      ST_POP_RD,
      ST_POP_LD,
      ST_DONE:    mem_off = '0;
      default:    mem_off = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      default_deadline_r <= DEFAULT_DEADLINE_RESET;
      count_r            <= '0;
      head_ptr_r         <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) default_deadline_r <= cfg_wdata;
      if (accept) begin
        if (in_data.kind == KIND_INSERT) begin
          if (!is_full) count_r <= count_r + CW'(1);
        end else if (!is_empty) begin
          count_r    <= count_r - CW'(1);
          head_ptr_r <= mem_addr;
        end
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_r.id        <= in_data.task_id;
          req_r.deadline  <= (in_data.deadline == '0) ? default_deadline_r
                                                      : in_data.deadline;
          req_r.type_code <= in_data.type_code;
          k_r             <= PW'(count_r);
          removed_r       <= '0;
          status_r        <= STATUS_DONE;
          if (in_data.kind == KIND_INSERT) begin
            if (is_full) status_r <= STATUS_FULL;
          end else if (is_empty) begin
            status_r <= STATUS_EMPTY;
          end else begin
            removed_r <= head_r;
          end
        end
      end
      ST_INS_CMP: if (shift) k_r <= k_r - PW'(1);
      ST_INS_WR:  head_r <= req_r;
      ST_POP_LD:  head_r <= mem_rdata;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_r.status           <= status_r;
          out_data_r.removed_id       <= removed_r.id;
          out_data_r.removed_deadline <= removed_r.deadline;
          out_data_r.removed_type     <= removed_r.type_code;
          out_data_r.head_valid       <= !is_empty;
          out_data_r.head_id          <= is_empty ? '0 : head_r.id;
          out_data_r.head_deadline    <= is_empty ? '0 : head_r.deadline;
          out_data_r.entry_count      <= 5'(count_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/dotq_checker.sv =====
// ----------------------------------------------------------------------------
// dotq_checker
// Port-level checks of the deadline-ordered task queue.
// ----------------------------------------------------------------------------
module dotq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dotq_pkg::dotq_out_t out_data
);
  import dotq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (QUEUE_DEPTH > 31) ||
                  (out_data.head_valid == (out_data.entry_count != 5'd0)))
    else $error("head valid disagrees with entry count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FULL |->
      out_data.entry_count == 5'(QUEUE_DEPTH))
    else $error("full status without a full queue");

  a_no_removed_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_DONE |->
      out_data.removed_id == '0 && out_data.removed_deadline == '0 &&
      out_data.removed_type == '0)
    else $error("removed task reported on a failed request");

endmodule

bind deadline_ordered_task_queue_top dotq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dotq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_deadline_ordered_task_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_ordered_task_queue_top
// Self-checking bench for the earliest-deadline-first task queue.
// A driver feeds insert and pop requests from a queue that the stimulus
// process fills phase by phase, and a monitor compares each result with a
// sorted-list model of the queue. Both channels idle and stall at random.
// The default deadline is rewritten between phases, only when nothing is
// in flight.
// ----------------------------------------------------------------------------
module tb_deadline_ordered_task_queue_top;
  import dotq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int LONG_STALL = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  dotq_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  dotq_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  dotq_in_t    pending_requests[$];
  dotq_out_t   expected_results[$];
  dotq_entry_t edf_entries[$];
  logic [31:0] dflt_deadline = DEFAULT_DEADLINE_RESET;

  int          failures          = 0;
  bit          idle_free         = 1'b0;
  int unsigned sender_gap        = 0;
  int unsigned recv_gap          = 0;
  int unsigned long_stall_left   = 0;
  int unsigned long_stalls_asked = 0;
  int unsigned long_stalls_taken = 0;

  deadline_ordered_task_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_free || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dotq_in_t task_request(logic kind, logic [31:0] id,
                                            logic [31:0] dl, logic [7:0] ty);
    dotq_in_t req;
    req.kind      = kind;
    req.task_id   = id;
    req.deadline  = dl;
    req.type_code = ty;
    return req;
  endfunction

  function automatic dotq_in_t make_request(int unsigned insert_pct);
    int unsigned r;
    logic [31:0] dl;
    r = $urandom_range(0, 9);
    if (r < 2) dl = '0;
    else if (r < 5) dl = $urandom_range(1, 8);
    else if (r == 5) dl = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
    else if (r == 6) dl = dflt_deadline;
    else dl = $urandom();
    return task_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP,
                        $urandom(), dl, 8'($urandom_range(0, 255)));
  endfunction

  // Apply one request to the sorted list and return the result it causes.
  function automatic dotq_out_t predict_edf(dotq_in_t req);
    dotq_out_t   res;
    dotq_entry_t ent;
    int          pos;
    res = '0;
    res.status = STATUS_DONE;
    if (req.kind == KIND_INSERT) begin
      if (edf_entries.size() >= QDEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        ent.id        = req.task_id;
        ent.deadline  = (req.deadline == '0) ? dflt_deadline : req.deadline;
        ent.type_code = req.type_code;
        pos = 0;
        while (pos < edf_entries.size() && edf_entries[pos].deadline < ent.deadline) pos++;
        edf_entries.insert(pos, ent);
      end
    end else if (edf_entries.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      ent = edf_entries.pop_front();
      res.removed_id       = ent.id;
      res.removed_deadline = ent.deadline;
      res.removed_type     = ent.type_code;
    end
    if (edf_entries.size() != 0) begin
      res.head_valid    = 1'b1;
      res.head_id       = edf_entries[0].id;
      res.head_deadline = edf_entries[0].deadline;
    end
    res.entry_count = 5'(edf_entries.size());
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      sender_gap <= 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_edf(in_data));
        offer = 1'b0;
      end
      if (!offer) begin
        if (sender_gap != 0) begin
          sender_gap <= sender_gap - 1;
        end else if (pending_requests.size() != 0) begin
          in_data    <= pending_requests.pop_front();
          offer      = 1'b1;
          sender_gap <= pick_gap();
        end
      end
      in_valid <= offer;
    end
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_stall_left != 0) begin
      out_ready       <= 1'b0;
      long_stall_left <= long_stall_left - 1;
    end else if (long_stalls_taken < long_stalls_asked) begin
      out_ready         <= 1'b0;
      long_stall_left   <= LONG_STALL;
      long_stalls_taken <= long_stalls_taken + 1;
    end else if (recv_gap != 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
      recv_gap  <= pick_gap();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    dotq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: 0x%0h", out_data);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",           32'(want.status),           32'(out_data.status));
        check_field("removed_id",       want.removed_id,            out_data.removed_id);
        check_field("removed_deadline", want.removed_deadline,      out_data.removed_deadline);
        check_field("removed_type",     32'(want.removed_type),     32'(out_data.removed_type));
        check_field("head_valid",       32'(want.head_valid),       32'(out_data.head_valid));
        check_field("head_id",          want.head_id,               out_data.head_id);
        check_field("head_deadline",    want.head_deadline,         out_data.head_deadline);
        check_field("entry_count",      32'(want.entry_count),      32'(out_data.entry_count));
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_default(logic [31:0] value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    dflt_deadline = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int n, int unsigned insert_pct);
    @(negedge clk);
    repeat (n) pending_requests.push_back(make_request(insert_pct));
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_requests.push_back(task_request(KIND_POP, '1, '1, 8'hFF));
    pending_requests.push_back(task_request(KIND_INSERT, 32'h1111, '0, 8'h01));
    pending_requests.push_back(task_request(KIND_INSERT, '1, '1, 8'hFF));
    pending_requests.push_back(task_request(KIND_INSERT, '0, 32'd1, 8'h00));
    pending_requests.push_back(task_request(KIND_INSERT, 32'hA, 32'd500, 8'h0A));
    pending_requests.push_back(task_request(KIND_INSERT, 32'hB, 32'd500, 8'h0B));
    pending_requests.push_back(task_request(KIND_INSERT, 32'h2222, 32'd10000, 8'h02));
    // fill to capacity, then one insert too many
    repeat (QDEPTH - 6) pending_requests.push_back(make_request(100));
    pending_requests.push_back(task_request(KIND_INSERT, 32'h3333, 32'd7, 8'h33));
    repeat (6) pending_requests.push_back(make_request(0));
    wait_drained();

    run_phase(200, 55);
    write_default('0);
    run_phase(200, 75);
    write_default(32'hFFFF_FFFF);
    idle_free = 1'b1;
    run_phase(200, 30);
    write_default(32'd1);
    // hold results off while a phase of requests is pending
    long_stalls_asked = long_stalls_asked + 1;
    run_phase(80, 80);
    idle_free = 1'b0;
    write_default($urandom());
    run_phase(250, 55);
    write_default(32'd5);
    run_phase(200, 50);

    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== deadline_ordered_task_queue_top.f =====
sv/dotq_pkg.sv
sv/dotq_mem.sv
sv/deadline_ordered_task_queue_top.sv
sv/dotq_checker.sv
tb/sv/tb_deadline_ordered_task_queue_top.sv
